>>> src/gmd_pkg.sv
// Shared types, constants and codes of the grid maze path search block.
`timescale 1ns / 1ps
`default_nettype none
package gmd_pkg;

   localparam int DEF_MAX_ROWS = 8;
   localparam int DEF_MAX_COLS = 8;

   localparam int DIM_W     = 4;
   localparam int POS_W     = 3;
   localparam int DIST_W    = 6;
   localparam int DIR_W     = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 1'b1;

   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_START_CHK,
      S_STEP,
      S_CHECK,
      S_POP,
      S_FOUND,
      S_NOPATH,
      S_EMIT_RD,
      S_EMIT_WR
   } search_state_type;

   typedef struct packed {
      logic             wr_en;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             blocked;
      logic             start;
   } load_type;

   typedef struct packed {
      logic              path_found;
      logic [POS_W-1:0]  path_row;
      logic [POS_W-1:0]  path_col;
      logic [DIST_W-1:0] path_distance;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/gmd_if.sv
// Request and response channel interfaces of the grid maze path search block.
`timescale 1ns / 1ps
`default_nettype none
interface gmd_req_if;
   logic valid;
   logic ready;
   logic cell_blocked;
   logic last_cell;

   modport source (output valid, output cell_blocked, output last_cell, input ready);
   modport sink (input valid, input cell_blocked, input last_cell, output ready);
endinterface

interface gmd_rsp_if;
   import gmd_pkg::*;
   logic              valid;
   logic              ready;
   logic              path_found;
   logic [POS_W-1:0]  path_row;
   logic [POS_W-1:0]  path_col;
   logic [DIST_W-1:0] path_distance;
   logic              last;

   modport source (output valid, output path_found, output path_row, output path_col,
                   output path_distance, output last, input ready);
   modport sink (input valid, input path_found, input path_row, input path_col,
                 input path_distance, input last, output ready);
endinterface
`default_nettype wire

>>> src/gmd_loader.sv
// Cell load counter: places incoming cells in row-major order and realigns after a resize.
`timescale 1ns / 1ps
`default_nettype none
module gmd_loader #(
   parameter int MAX_ROWS = gmd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmd_pkg::DEF_MAX_COLS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_accept,
   input  wire logic                       cell_blocked,
   input  wire logic                       last_cell,
   input  wire logic                       csr_write,
   input  wire logic [gmd_pkg::DIM_W-1:0]  rows_eff,
   input  wire logic [gmd_pkg::DIM_W-1:0]  cols_eff,
   output gmd_pkg::load_type               load,
   output logic                            busy
);
   import gmd_pkg::*;

   localparam int NCELLS = MAX_ROWS * MAX_COLS;
   localparam int CNT_W  = ($clog2(NCELLS + 1) > DIM_W) ? $clog2(NCELLS + 1) : DIM_W;
   localparam int CMP_W  = CNT_W + DIM_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic             norm_ff, norm_in;
   logic             loading;
   logic [CNT_W-1:0] cols_ext;

   assign cols_ext = CNT_W'(cols_eff);
   assign loading  = CMP_W'(count_ff) < (CMP_W'(rows_eff) * CMP_W'(cols_eff));

   always_comb begin
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      norm_in      = norm_ff;
      load.wr_en   = 1'b0;
      load.row     = POS_W'(row_ff);
      load.col     = POS_W'(col_ff);
      load.blocked = cell_blocked;
      load.start   = 1'b0;

      if (norm_ff) begin
         // Repeated subtraction turns the cell count into row and column.
         if (col_ff >= cols_ext) begin
            col_in = col_ff - cols_ext;
            row_in = row_ff + CNT_W'(1);
         end else begin
            norm_in = 1'b0;
         end
      end else if (req_accept) begin
         if (loading) begin
            load.wr_en = 1'b1;
            count_in   = count_ff + CNT_W'(1);
            if (col_ff + CNT_W'(1) == cols_ext) begin
               col_in = '0;
               row_in = row_ff + CNT_W'(1);
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
         if (last_cell) begin
            load.start = 1'b1;
            count_in   = '0;
            row_in     = '0;
            col_in     = '0;
         end
      end

      // A new column count moves the next cell's place; recompute it from the count.
      if (csr_write) begin
         norm_in = 1'b1;
         row_in  = '0;
         col_in  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         norm_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         norm_ff  <= norm_in;
      end
   end

   assign busy = norm_ff;

endmodule
`default_nettype wire

>>> src/gmd_search.sv
// Grid and stack memories with the depth-first search and path emission sequencer.
`timescale 1ns / 1ps
`default_nettype none
module gmd_search #(
   parameter int MAX_ROWS = gmd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmd_pkg::DEF_MAX_COLS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  gmd_pkg::load_type               load,
   input  wire logic [gmd_pkg::DIM_W-1:0]  rows_eff,
   input  wire logic [gmd_pkg::DIM_W-1:0]  cols_eff,
   output gmd_pkg::rsp_type                rsp,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            idle
);
   import gmd_pkg::*;

   localparam int NCELLS = MAX_ROWS * MAX_COLS;
   localparam int IW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
   localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DW     = $clog2(NCELLS + 1);
   localparam int SW     = DIR_W + RW + CW;

   function automatic logic [IW-1:0] cell_idx(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return IW'(r * MAX_COLS + c);
   endfunction

   search_state_type state_ff, state_in;

   logic [RW-1:0]    top_row_ff, top_row_in;
   logic [CW-1:0]    top_col_ff, top_col_in;
   logic [DIR_W-1:0] top_dir_ff, top_dir_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [RW-1:0]    nb_row_ff, nb_row_in;
   logic [CW-1:0]    nb_col_ff, nb_col_in;
   logic [IW-1:0]    emit_ptr_ff, emit_ptr_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NCELLS-1:0] visited_ff;

   logic            grid_mem [NCELLS];
   logic            grid_rd_ff;
   logic [SW-1:0]   stk_mem [NCELLS];
   logic [SW-1:0]   stk_rd_ff;

   logic            grid_re;
   logic [IW-1:0]   grid_raddr;
   logic            stk_re, stk_we;
   logic [IW-1:0]   stk_raddr, stk_waddr;
   logic [SW-1:0]   stk_wdata;
   logic            visited_clr, visited_set;
   logic [IW-1:0]   visited_idx;

   logic            slot_free;
   logic [RW-1:0]   start_row;
   logic [CW-1:0]   start_col;
   logic [IW-1:0]   nb_idx;
   logic            nb_ok;
   logic [RW-1:0]   cand_row;
   logic [CW-1:0]   cand_col;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign start_row = RW'(rows_eff - DIM_W'(1));
   assign start_col = CW'(cols_eff - DIM_W'(1));
   assign nb_idx    = cell_idx(nb_row_ff, nb_col_ff);

   // Neighbor of the top cell in the direction to try next, and whether it lies in the grid.
   always_comb begin
      cand_row = top_row_ff;
      cand_col = top_col_ff;
      nb_ok    = 1'b0;
      unique case (top_dir_ff)
         DIR_DOWN: begin
            cand_row = top_row_ff + RW'(1);
            nb_ok    = (DIM_W'(top_row_ff) + DIM_W'(1)) < rows_eff;
         end
         DIR_LEFT: begin
            cand_col = top_col_ff - CW'(1);
            nb_ok    = top_col_ff != '0;
         end
         DIR_UP: begin
            cand_row = top_row_ff - RW'(1);
            nb_ok    = top_row_ff != '0;
         end
         DIR_RIGHT: begin
            cand_col = top_col_ff + CW'(1);
            nb_ok    = (DIM_W'(top_col_ff) + DIM_W'(1)) < cols_eff;
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      top_row_in   = top_row_ff;
      top_col_in   = top_col_ff;
      top_dir_in   = top_dir_ff;
      depth_in     = depth_ff;
      nb_row_in    = nb_row_ff;
      nb_col_in    = nb_col_ff;
      emit_ptr_in  = emit_ptr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      grid_re      = 1'b0;
      grid_raddr   = nb_idx;
      stk_re       = 1'b0;
      stk_raddr    = emit_ptr_ff;
      stk_we       = 1'b0;
      stk_waddr    = IW'(depth_ff - DW'(1));
      stk_wdata    = {top_dir_ff, top_row_ff, top_col_ff};
      visited_clr  = 1'b0;
      visited_set  = 1'b0;
      visited_idx  = nb_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (load.start) begin
               state_in = S_START;
            end
         end
         S_START: begin
            // The last cell was written at the previous edge, so this read sees it.
            grid_re     = 1'b1;
            grid_raddr  = cell_idx(start_row, start_col);
            visited_clr = 1'b1;
            state_in    = S_START_CHK;
         end
         S_START_CHK: begin
            if (grid_rd_ff) begin
               state_in = S_NOPATH;
            end else begin
               visited_set = 1'b1;
               visited_idx = cell_idx(start_row, start_col);
               top_row_in  = start_row;
               top_col_in  = start_col;
               top_dir_in  = DIR_DOWN;
               depth_in    = DW'(1);
               if (start_row == '0 && start_col == '0) begin
                  state_in = S_FOUND;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            if (top_dir_ff > DIR_RIGHT) begin
               if (depth_ff == DW'(1)) begin
                  depth_in = '0;
                  state_in = S_NOPATH;
               end else begin
                  stk_re    = 1'b1;
                  stk_raddr = IW'(depth_ff - DW'(2));
                  state_in  = S_POP;
               end
            end else begin
               top_dir_in = top_dir_ff + DIR_W'(1);
               if (nb_ok) begin
                  nb_row_in  = cand_row;
                  nb_col_in  = cand_col;
                  grid_re    = 1'b1;
                  grid_raddr = cell_idx(cand_row, cand_col);
                  state_in   = S_CHECK;
               end
            end
         end
         S_POP: begin
            top_dir_in = stk_rd_ff[SW-1 -: DIR_W];
            top_row_in = stk_rd_ff[CW +: RW];
            top_col_in = stk_rd_ff[CW-1:0];
            depth_in   = depth_ff - DW'(1);
            state_in   = S_STEP;
         end
         S_CHECK: begin
            if (!grid_rd_ff && !visited_ff[nb_idx]) begin
               // Push: the old top goes to memory with its direction already advanced.
               visited_set = 1'b1;
               stk_we      = 1'b1;
               top_row_in  = nb_row_ff;
               top_col_in  = nb_col_ff;
               top_dir_in  = DIR_DOWN;
               depth_in    = depth_ff + DW'(1);
               if (nb_idx == '0) begin
                  state_in = S_FOUND;
               end else begin
                  state_in = S_STEP;
               end
            end else begin
               state_in = S_STEP;
            end
         end
         S_FOUND: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.path_found    = 1'b1;
               rsp_in.path_row      = POS_W'(top_row_ff);
               rsp_in.path_col      = POS_W'(top_col_ff);
               rsp_in.path_distance = DIST_W'(depth_ff - DW'(1));
               rsp_in.last          = depth_ff == DW'(1);
               if (depth_ff == DW'(1)) begin
                  depth_in = '0;
                  state_in = S_IDLE;
               end else begin
                  emit_ptr_in = IW'(depth_ff - DW'(2));
                  state_in    = S_EMIT_RD;
               end
            end
         end
         S_NOPATH: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.path_found    = 1'b0;
               rsp_in.path_row      = '0;
               rsp_in.path_col      = '0;
               rsp_in.path_distance = '0;
               rsp_in.last          = 1'b1;
               depth_in             = '0;
               state_in             = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            stk_re   = 1'b1;
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.path_found    = 1'b1;
               rsp_in.path_row      = POS_W'(stk_rd_ff[CW +: RW]);
               rsp_in.path_col      = POS_W'(stk_rd_ff[CW-1:0]);
               rsp_in.path_distance = DIST_W'(depth_ff - DW'(1));
               rsp_in.last          = emit_ptr_ff == '0;
               if (emit_ptr_ff == '0) begin
                  depth_in = '0;
                  state_in = S_IDLE;
               end else begin
                  emit_ptr_in = emit_ptr_ff - IW'(1);
                  state_in    = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_row_ff  <= top_row_in;
      top_col_ff  <= top_col_in;
      top_dir_ff  <= top_dir_in;
      nb_row_ff   <= nb_row_in;
      nb_col_ff   <= nb_col_in;
      emit_ptr_ff <= emit_ptr_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (visited_clr) begin
         visited_ff <= '0;
      end else if (visited_set) begin
         visited_ff[visited_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load.wr_en) begin
         grid_mem[cell_idx(RW'(load.row), CW'(load.col))] <= load.blocked;
      end
      if (grid_re) begin
         grid_rd_ff <= grid_mem[grid_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign idle      = state_ff == S_IDLE;

endmodule
`default_nettype wire

>>> src/grid_maze_dfs_path.sv
// Top level of the grid maze depth-first path search block.
// Usage:
//   Requests on req_chan carry one maze cell each (cell_blocked), in row-major
//   order over the rows_used by cols_used grid; last_cell marks the final cell
//   and starts the search from the bottom-right corner toward cell (0,0).
//   Cells beyond the grid size in one maze are ignored.
//   While loading, one request is taken per cycle. After a csr write, the load
//   position is recomputed from the cell count, one subtraction per cycle.
//   After the last cell, req_chan.ready stays low during the search; the start,
//   each neighbor tried inside the grid and each backtrack step wait on a
//   registered read of the grid or stack memory.
//   Results on rsp_chan list the path from (0,0) back to the start with its
//   distance, each cell after (0,0) read from the stack memory into the output register;
//   with no path, a single result with path_found low. last marks the final one.
//   A result sits in the output register until rsp_chan.ready; the search stalls
//   behind it, but the next maze may start loading while the final result waits.
//   Reset sets both grid dimensions to 8 and the load position to the first
//   cell; the grid memory holds nothing meaningful until cells are loaded.
`timescale 1ns / 1ps
`default_nettype none
module grid_maze_dfs_path #(
   parameter int MAX_ROWS = gmd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmd_pkg::DEF_MAX_COLS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   gmd_req_if.sink                            req_chan,
   gmd_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [gmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gmd_pkg::DIM_W-1:0]     csr_wdata
);
   import gmd_pkg::*;

   logic [DIM_W-1:0] rows_used_ff, rows_used_in;
   logic [DIM_W-1:0] cols_used_ff, cols_used_in;
   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic             req_accept;
   logic             load_busy;
   logic             search_idle;
   load_type         load;
   rsp_type          rsp;
   logic             rsp_valid;

   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_USED: rows_used_in = csr_wdata;
            CSR_COLS_USED: cols_used_in = csr_wdata;
            default: begin
               rows_used_in = rows_used_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= DIM_RESET;
         cols_used_ff <= DIM_RESET;
      end else begin
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
      end
   end

   // Zero counts as one and anything above the maximum as the maximum.
   assign rows_eff = (rows_used_ff == '0) ? DIM_W'(1) :
                     (rows_used_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_used_ff;
   assign cols_eff = (cols_used_ff == '0) ? DIM_W'(1) :
                     (cols_used_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_used_ff;

   assign req_chan.ready = search_idle && !load_busy;
   assign req_accept     = req_chan.valid && req_chan.ready;

   gmd_loader #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_loader (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .cell_blocked (req_chan.cell_blocked),
      .last_cell    (req_chan.last_cell),
      .csr_write    (csr_wr_en),
      .rows_eff     (rows_eff),
      .cols_eff     (cols_eff),
      .load         (load),
      .busy         (load_busy)
   );

   gmd_search #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .rows_eff  (rows_eff),
      .cols_eff  (cols_eff),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .idle      (search_idle)
   );

   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.path_found    = rsp.path_found;
   assign rsp_chan.path_row      = rsp.path_row;
   assign rsp_chan.path_col      = rsp.path_col;
   assign rsp_chan.path_distance = rsp.path_distance;
   assign rsp_chan.last          = rsp.last;

endmodule
`default_nettype wire

>>> dv/grid_maze_dfs_path_test.sv
// Self-checking testbench for the grid maze depth-first path search block.
`timescale 1ns / 1ps
module grid_maze_dfs_path_test;
   import gmd_pkg::*;

   localparam int TOTAL_ITEMS = 430;
   localparam int QUIET_LIMIT = 10000;
   localparam int HOLD_CYCLES = 2000;
   localparam int CSR_SETTLE  = 4;
   localparam int END_SETTLE  = 60;
   localparam int GRID_CELLS  = DEF_MAX_ROWS * DEF_MAX_COLS;

   localparam rsp_type FOUND_ORIGIN = '{path_found: 1'b1, path_row: 3'd0, path_col: 3'd0,
                                        path_distance: 6'd0, last: 1'b1};
   localparam rsp_type NO_PATH = '{path_found: 1'b0, path_row: 3'd0, path_col: 3'd0,
                                   path_distance: 6'd0, last: 1'b1};

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [DIM_W-1:0]     wdata;
      logic                 wall;
      logic                 fin;
      bit                   typed;
      rsp_type              want;
   } step_row_type;

   typedef struct {
      bit      typed;
      rsp_type want;
   } pinned_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   gmd_req_if req_bus();
   gmd_rsp_if rsp_bus();

   grid_maze_dfs_path u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model of the block: register copies, maze contents and the search stack.
   logic [DIM_W-1:0] rows_reg = DIM_RESET;
   logic [DIM_W-1:0] cols_reg = DIM_RESET;
   bit               cell_wall [GRID_CELLS];
   bit               cell_seen [GRID_CELLS];
   int               trail_cell [GRID_CELLS];
   logic [DIR_W-1:0] trail_dir [GRID_CELLS];
   int               cells_loaded = 0;
   rsp_type          path_due [$];
   pinned_type       pinned_due [$];

   // Stimulus side bookkeeping, kept apart from the model.
   int  gen_rows = DEF_MAX_ROWS;
   int  gen_cols = DEF_MAX_COLS;
   int  gen_pos = 0;
   bit  cell_written [GRID_CELLS];
   int  items_sent = 0;
   int  send_idle_pct = 17;
   int  recv_idle_pct = 65;
   bit  hold_arm = 1'b0;
   int  err_cnt = 0;

   pinned_type pin;
   int         n_before;
   rsp_type    want;

   step_row_type plan [28] = '{
      '{1'b1, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b1, CSR_COLS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b1, 1'b1, FOUND_ORIGIN},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b1, 1'b1, 1'b1, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b1, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b1, 1'b1, 1'b1, FOUND_ORIGIN},
      '{1'b1, CSR_ROWS_USED, 4'd2,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b1, CSR_COLS_USED, 4'd2,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b1, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b1, 1'b1, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b1, 1'b1, 1'b1, NO_PATH},
      '{1'b1, CSR_ROWS_USED, 4'd1,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b1, CSR_COLS_USED, 4'd15, 1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b0, 1'b0, NO_PATH},
      '{1'b0, CSR_ROWS_USED, 4'd0,  1'b0, 1'b1, 1'b0, NO_PATH}
   };

   function automatic int fit_dim(logic [DIM_W-1:0] raw, int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   // Depth-first walk from the bottom-right corner; queues the path cells it finds.
   function automatic void solve_maze(int rows, int cols);
      int               depth;
      int               here;
      int               nr;
      int               nc;
      int               nxt;
      int               start;
      logic [DIR_W-1:0] dir;
      bit               hit;
      hit = 1'b0;
      depth = 0;
      foreach (cell_seen[i]) cell_seen[i] = 1'b0;
      start = (rows - 1) * DEF_MAX_COLS + cols - 1;
      if (!cell_wall[start]) begin
         cell_seen[start] = 1'b1;
         trail_cell[0] = start;
         trail_dir[0] = DIR_DOWN;
         depth = 1;
         hit = (start == 0);
      end
      while (!hit && depth > 0) begin
         here = trail_cell[depth-1];
         dir = trail_dir[depth-1];
         if (dir > DIR_RIGHT) begin
            depth--;
         end else begin
            trail_dir[depth-1] = dir + 1'b1;
            nr = here / DEF_MAX_COLS;
            nc = here % DEF_MAX_COLS;
            case (dir)
               DIR_DOWN: nr = nr + 1;
               DIR_LEFT: nc = nc - 1;
               DIR_UP:   nr = nr - 1;
               default:  nc = nc + 1;
            endcase
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
               nxt = nr * DEF_MAX_COLS + nc;
               if (!cell_wall[nxt] && !cell_seen[nxt]) begin
                  cell_seen[nxt] = 1'b1;
                  trail_cell[depth] = nxt;
                  trail_dir[depth] = DIR_DOWN;
                  depth++;
                  hit = (nxt == 0);
               end
            end
         end
      end
      if (!hit) begin
         path_due.push_back(NO_PATH);
      end else begin
         // The stack holds the path from the start to the origin; emit it origin first.
         for (int i = depth; i > 0; i--) begin
            path_due.push_back('{path_found: 1'b1,
                                 path_row: POS_W'(trail_cell[i-1] / DEF_MAX_COLS),
                                 path_col: POS_W'(trail_cell[i-1] % DEF_MAX_COLS),
                                 path_distance: DIST_W'(depth - 1),
                                 last: (i == 1)});
         end
      end
   endfunction

   function automatic void take_cell(logic wall, logic fin);
      int rows;
      int cols;
      rows = fit_dim(rows_reg, DEF_MAX_ROWS);
      cols = fit_dim(cols_reg, DEF_MAX_COLS);
      if (cells_loaded < rows * cols) begin
         cell_wall[(cells_loaded / cols) * DEF_MAX_COLS + cells_loaded % cols] = wall;
         cells_loaded++;
      end
      if (fin) begin
         solve_maze(rows, cols);
         cells_loaded = 0;
      end
   endfunction

   task automatic note_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_cnt++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (path_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repeat (CSR_SETTLE) @(posedge clock);
      if (idx == CSR_ROWS_USED) gen_rows = fit_dim(val, DEF_MAX_ROWS);
      else gen_cols = fit_dim(val, DEF_MAX_COLS);
   endtask

   task automatic send_cell(logic wall, logic fin, bit typed, rsp_type want_fixed);
      pinned_due.push_back('{typed, want_fixed});
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cell_blocked <= wall;
      req_bus.last_cell <= fin;
      do @(posedge clock); while (!req_bus.ready);
      if (gen_pos < gen_rows * gen_cols) begin
         cell_written[(gen_pos / gen_cols) * DEF_MAX_COLS + gen_pos % gen_cols] = 1'b1;
         gen_pos++;
      end
      if (fin) gen_pos = 0;
      items_sent++;
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 60) return DIM_W'($urandom_range(1, 3));
      if (roll < 80) return DIM_W'($urandom_range(4, 7));
      if (roll < 92) return DIM_W'(8);
      return DIM_W'($urandom_range(9, 15));
   endfunction

   task automatic run_maze(bit keep_dims);
      int   area;
      int   len;
      int   pct;
      bit   all_known;
      logic wall;
      if (!keep_dims) begin
         if ($urandom_range(0, 99) < 35) begin
            write_reg(CSR_ROWS_USED, pick_dim());
            write_reg(CSR_COLS_USED, pick_dim());
         end else if ($urandom_range(0, 7) == 0) begin
            wait_drained();
         end
      end
      area = gen_rows * gen_cols;
      all_known = 1'b1;
      for (int k = 0; k < area; k++) begin
         if (!cell_written[(k / gen_cols) * DEF_MAX_COLS + k % gen_cols]) all_known = 1'b0;
      end
      len = area;
      case ($urandom_range(0, 7))
         0: len = area + $urandom_range(1, 4);
         // A short maze reuses old cells, so every cell of the grid must hold real data.
         1: if (all_known) len = $urandom_range(1, area);
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0:       pct = 0;
         1:       pct = 15;
         2:       pct = 30;
         3:       pct = 45;
         default: pct = 75;
      endcase
      for (int k = 0; k < len; k++) begin
         wall = ($urandom_range(0, 99) < pct);
         if ((k == 0 || k == area - 1) && $urandom_range(0, 99) < 85) wall = 1'b0;
         send_cell(wall, k == len - 1, 1'b0, NO_PATH);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ROWS_USED) rows_reg = csr_wdata;
            else cols_reg = csr_wdata;
         end
         if (req_bus.valid && req_bus.ready) begin
            pin = pinned_due.pop_front();
            n_before = path_due.size();
            take_cell(req_bus.cell_blocked, req_bus.last_cell);
            if (pin.typed) begin
               while (path_due.size() > n_before) void'(path_due.pop_back());
               path_due.push_back(pin.want);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (path_due.size() == 0) begin
               note_mismatch("path cell returned with none outstanding");
            end else begin
               want = path_due.pop_front();
               if (rsp_bus.path_found !== want.path_found)
                  note_mismatch($sformatf("path_found %0d, predicted %0d",
                                          rsp_bus.path_found, want.path_found));
               if (rsp_bus.path_row !== want.path_row)
                  note_mismatch($sformatf("path_row %0d, predicted %0d",
                                          rsp_bus.path_row, want.path_row));
               if (rsp_bus.path_col !== want.path_col)
                  note_mismatch($sformatf("path_col %0d, predicted %0d",
                                          rsp_bus.path_col, want.path_col));
               if (rsp_bus.path_distance !== want.path_distance)
                  note_mismatch($sformatf("path_distance %0d, predicted %0d",
                                          rsp_bus.path_distance, want.path_distance));
               if (rsp_bus.last !== want.last)
                  note_mismatch($sformatf("last %0d, predicted %0d",
                                          rsp_bus.last, want.last));
            end
         end
      end
   end

   // Result side: random back-pressure, plus one long hold that backs the block up.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      bit hold_done;
      int steady_left;
      hold_done = 1'b0;
      steady_left = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cell_blocked <= 1'b0;
      req_bus.last_cell <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ROWS_USED;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_reg(plan[i].idx, plan[i].wdata);
         else send_cell(plan[i].wall, plan[i].fin, plan[i].typed, plan[i].want);
      end

      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent < 150) begin
            send_idle_pct = 17;
            recv_idle_pct = 65;
         end else if (items_sent < 290) begin
            send_idle_pct = 65;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (!hold_done && items_sent >= 60) begin
            hold_arm = 1'b1;
            hold_done = 1'b1;
            // Mazes without register writes keep requests coming while results are held.
            steady_left = 3;
         end
         run_maze(steady_left > 0);
         if (steady_left > 0) steady_left--;
      end

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (err_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
